FILE: design/greedy_graph_coloring_top_macros.svh
// ----------------------------------------------------------------------------
// greedy graph coloring assertion macros
// shared assertion wrappers for the coloring block
// ----------------------------------------------------------------------------
`ifndef GREEDY_GRAPH_COLORING_TOP_MACROS_SVH
`define GREEDY_GRAPH_COLORING_TOP_MACROS_SVH

// clocked check, quiet while reset is asserted
`define GGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define GGC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ggc_pkg.sv
// ----------------------------------------------------------------------------
// ggc_pkg
// shared types and constants of the greedy graph coloring block
// ----------------------------------------------------------------------------
package ggc_pkg;

	localparam int NODES      = 16;
	localparam int COLOURS    = 4;
	localparam int NODE_IDX_W = $clog2(NODES);
	localparam int CNT_W      = $clog2(NODES + 1);
	localparam int COL_IDX_W  = $clog2(COLOURS);

	// fixed field widths of the ports
	localparam int NODE_W     = 4;
	localparam int COLOUR_W   = 2;
	localparam int COUNT_W    = 5;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	// operation codes
	localparam logic FUNC_EDGE = 1'b0;
	localparam logic FUNC_RUN  = 1'b1;

	// register index (paddr[2])
	localparam logic REG_NODE_COUNT = 1'b0;

	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(16);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} ggc_state_t;

	typedef struct packed {
		logic load_edge;
		logic start;
		logic step;
	} ggc_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic last_node;
	} ggc_status_t;

endpackage

FILE: design/greedy_graph_coloring_top.sv
// ----------------------------------------------------------------------------
// greedy_graph_coloring_top
// input channel (in_valid/in_stall): func 0 stores a conflict edge
//   from_node/to_node, func 1 starts a coloring run over nodes 0..count-1
// output channel (out_valid/out_stall): one word per node of a run, node
//   index, lowest free colour, uncoloured flag, last on the final node
// edge words are taken back to back while idle and give no output word
// a run is accepted only while idle; the state register then enters run,
//   and each node step writes the output register, one node a cycle while
//   the output word is not stalled
// the per-node figure comes from one adjacency row read and one mask compare
//   per colour each cycle; in_stall stays high for the whole run
// a stalled output word holds, and the node walk pauses until it is taken
// apb register 0 (byte 0): node_count, 0 acts as 1, above 16 acts as 16
// reset clears the adjacency matrix, sets node_count to 16, empties output
// ----------------------------------------------------------------------------
`include "greedy_graph_coloring_top_macros.svh"

module greedy_graph_coloring_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [ggc_pkg::NODE_W-1:0]    from_node,
	input  logic [ggc_pkg::NODE_W-1:0]    to_node,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ggc_pkg::NODE_W-1:0]    node,
	output logic [ggc_pkg::COLOUR_W-1:0]  colour,
	output logic                          uncoloured,
	output logic                          last,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ggc_pkg::ADDR_W-1:0]    paddr,
	input  logic [ggc_pkg::DATA_W-1:0]    pwdata,
	output logic [ggc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import ggc_pkg::*;

	ggc_cmd_t            cmd;
	ggc_status_t         status;
	logic [COUNT_W-1:0]  node_count_q;
	logic                cfg_wr;

	// register port: no wait states, register index in paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// read back, unknown registers read as zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_NODE_COUNT) begin
			prdata = DATA_W'(node_count_q);
		end
	end

	// sequencer
	ggc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// storage and per-node colour pick
	ggc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.from_node  (from_node),
		.to_node    (to_node),
		.node_count (node_count_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.node       (node),
		.colour     (colour),
		.uncoloured (uncoloured),
		.last       (last)
	);

	// a run start always leaves the block busy
	`GGC_ASSERT(a_start_busy, cmd.start |=> in_stall, "run start did not enter busy")
	// the final node step always frees the input
	`GGC_ASSERT(a_last_idle, (cmd.step && status.last_node) |=> !in_stall, "run did not end")
	// every node step lands a word in the output register
	`GGC_ASSERT(a_step_out, cmd.step |=> out_valid, "step lost")
	// never a start and a step in the same cycle
	`GGC_ASSERT_ALWAYS(a_cmd_excl, !(cmd.start && cmd.step), "start and step together")

endmodule

FILE: design/ggc_ctrl.sv
// ----------------------------------------------------------------------------
// ggc_ctrl
// sequencer: takes input words, walks the nodes of a run
// ----------------------------------------------------------------------------
module ggc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                func,
	input  ggc_pkg::ggc_status_t status,
	output ggc_pkg::ggc_cmd_t    cmd,
	output logic                in_stall
);
	import ggc_pkg::*;

	ggc_state_t state_q;
	ggc_state_t state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.step && status.last_node) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		accept        = in_valid && !in_stall;
		cmd.load_edge = accept && (func == FUNC_EDGE);
		cmd.start     = accept && (func == FUNC_RUN);
		cmd.step      = (state_q == ST_RUN) && status.slot_free;
	end

endmodule

FILE: design/ggc_dp.sv
// ----------------------------------------------------------------------------
// ggc_dp
// adjacency store, colour class masks, node counter and result register
// ----------------------------------------------------------------------------
module ggc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ggc_pkg::ggc_cmd_t             cmd,
	output ggc_pkg::ggc_status_t          status,
	input  logic [ggc_pkg::NODE_W-1:0]    from_node,
	input  logic [ggc_pkg::NODE_W-1:0]    to_node,
	input  logic [ggc_pkg::COUNT_W-1:0]   node_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ggc_pkg::NODE_W-1:0]    node,
	output logic [ggc_pkg::COLOUR_W-1:0]  colour,
	output logic                          uncoloured,
	output logic                          last
);
	import ggc_pkg::*;

	// symmetric conflict matrix: an edge sets both directions
	logic [NODES-1:0]      adj_q [NODES];
	// one node mask per colour, cleared at run start
	logic [NODES-1:0]      member_q [COLOURS];
	logic [NODE_IDX_W-1:0] node_q;

	logic                  out_valid_q;
	logic [NODE_W-1:0]     out_node_q;
	logic [COLOUR_W-1:0]   out_colour_q;
	logic                  out_unc_q;
	logic                  out_last_q;

	logic [NODES-1:0]      row;
	logic [COLOURS-1:0]    blocked;
	logic                  found;
	logic [COL_IDX_W-1:0]  pick;
	logic [CNT_W-1:0]      cnt_eff;
	logic                  edge_ok;
	logic [NODE_IDX_W-1:0] from_idx;
	logic [NODE_IDX_W-1:0] to_idx;

	always_comb begin
		if (node_count == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (32'(node_count) > NODES) begin
			cnt_eff = CNT_W'(NODES);
		end else begin
			cnt_eff = CNT_W'(node_count);
		end
	end

	always_comb begin
		row = adj_q[node_q];
		for (int c = 0; c < COLOURS; c++) begin
			blocked[c] = |(row & member_q[c]);
		end
		found = 1'b0;
		pick  = '0;
		for (int c = 0; c < COLOURS; c++) begin
			if (!blocked[c] && !found) begin
				found = 1'b1;
				pick  = COL_IDX_W'(c);
			end
		end
	end

	assign status.slot_free = !out_valid_q || !out_stall;
	assign status.last_node = (CNT_W'(node_q) == (cnt_eff - CNT_W'(1)));

	assign edge_ok  = (32'(from_node) < NODES) && (32'(to_node) < NODES);
	assign from_idx = NODE_IDX_W'(from_node);
	assign to_idx   = NODE_IDX_W'(to_node);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.load_edge && edge_ok) begin
			adj_q[from_idx][to_idx] <= 1'b1;
			adj_q[to_idx][from_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int c = 0; c < COLOURS; c++) begin
				member_q[c] <= '0;
			end
		end else if (cmd.step && found) begin
			member_q[pick][node_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				node_q <= '0;
			end else if (cmd.step) begin
				node_q <= node_q + NODE_IDX_W'(1);
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_node_q   <= NODE_W'(node_q);
			out_colour_q <= found ? COLOUR_W'(pick) : '0;
			out_unc_q    <= !found;
			out_last_q   <= status.last_node;
		end
	end

	assign out_valid  = out_valid_q;
	assign node       = out_node_q;
	assign colour     = out_colour_q;
	assign uncoloured = out_unc_q;
	assign last       = out_last_q;

endmodule
